// File: rtl/dss_pkg.sv
// ---------------------------------------------------------------------------
// dss_pkg
// Shared types, widths and constants of the diode sweep sequencer.
// ---------------------------------------------------------------------------
package dss_pkg;

    localparam int SAMPLES_PER_POINT = 10;
    localparam int NUM_POINTS        = 15;

    localparam int OPCODE_W    = 2;
    localparam int SAMPLE_W    = 12;
    localparam int POINT_W     = 4;
    localparam int DRIVE_W     = 4;
    localparam int READING_W   = 10;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 4;
    localparam int SUM_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int MODE_W      = 2;

    localparam int AVG_BIAS   = 20;
    localparam int SCALE_MUL  = 100;
    localparam int SCALE_DIV  = 420;

    // sum / SAMPLES_PER_POINT as a reciprocal multiply, exact over SUM_W bits
    localparam int AVG_W     = SUM_W;
    localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_POINT);
    localparam int AVG_MUL_W = SUM_W + 1;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL =
        AVG_MUL_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES_PER_POINT) - 64'd1)
                   / 64'(SAMPLES_PER_POINT));

    // x / SCALE_DIV as a reciprocal multiply, exact over SCALED_W bits
    localparam longint SCALED_MAX =
        (longint'(2**SUM_W - 1) + longint'(AVG_BIAS)) * longint'(SCALE_MUL);
    localparam int SCALED_W  = $clog2(SCALED_MAX + 1);
    localparam int DIV_SHIFT = SCALED_W + $clog2(SCALE_DIV);
    localparam int RECIP_W   = SCALED_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));

    typedef enum logic [OPCODE_W-1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_IGNORED  = 2'd2
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        SWEEP_ONE     = 2'd0,
        SWEEP_DOUBLE  = 2'd1,
        SWEEP_STRIDE2 = 2'd2,
        SWEEP_STRIDE1 = 2'd3
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SWEEP_MODE  = 2'd0,
        CFG_START_POINT = 2'd1,
        CFG_END_POINT   = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        t_mode              sweep_mode;
        logic [POINT_W-1:0] start_point;
        logic [POINT_W-1:0] end_point;
    } t_cfg;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_code;
        logic               drive_changed;
        t_status            status;
        logic               sweep_done;
        logic               store;
        logic               read;
        logic               clear;
        logic [POINT_W-1:0] point;
        logic [POINT_W-1:0] read_index;
    } t_ctl;

    typedef struct packed {
        t_ctl             ctl;
        logic [SUM_W-1:0] sum;
    } t_item;

    typedef struct packed {
        logic                 clear;
        logic                 wr;
        logic [POINT_W-1:0]   wr_index;
        logic [READING_W-1:0] wr_data;
        logic [POINT_W-1:0]   rd_index;
    } t_tbl_req;

endpackage

// File: rtl/dss_ctrl.sv
// ---------------------------------------------------------------------------
// dss_ctrl
// Sweep sequencing: configuration registers, point stepping, drive code and
// sample accumulation; decides each request's outcome in its accept cycle.
// ---------------------------------------------------------------------------
module dss_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [dss_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                          i_fire,
    input  logic [dss_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [dss_pkg::SAMPLE_W-1:0]  i_adc_sample,
    input  logic [dss_pkg::POINT_W-1:0]   i_read_index,
    output dss_pkg::t_item                o_item
);
    import dss_pkg::*;

    localparam int P_W = POINT_W + 2;

    t_cfg               r_cfg;
    logic               r_busy,  n_busy;
    logic [POINT_W-1:0] r_point, n_point;
    logic [DRIVE_W-1:0] r_drive, n_drive;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0]   r_sum,   n_sum;

    logic [SUM_W-1:0]   sum_inc;
    logic [COUNT_W-1:0] count_inc;
    logic [P_W-1:0]     first_p, next_p;
    logic               first_ok, next_ok;
    t_ctl               ctl;

    function automatic logic point_ok(input logic [P_W-1:0] p, input t_cfg c);
        logic in_range;
        in_range = (p < P_W'(NUM_POINTS));
        if (c.sweep_mode == SWEEP_DOUBLE) begin
            return in_range && ((p + P_W'(1)) <= P_W'(c.end_point));
        end
        return in_range && (p <= P_W'(c.end_point));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{sweep_mode: SWEEP_ONE, start_point: '0, end_point: '0};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SWEEP_MODE:  r_cfg.sweep_mode  <= t_mode'(i_cfg_data[MODE_W-1:0]);
                CFG_START_POINT: r_cfg.start_point <= i_cfg_data[POINT_W-1:0];
                CFG_END_POINT:   r_cfg.end_point   <= i_cfg_data[POINT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sum_inc   = r_sum + SUM_W'(i_adc_sample);
        count_inc = r_count + COUNT_W'(1);

        case (r_cfg.sweep_mode)
            SWEEP_ONE: begin
                first_p  = P_W'(r_cfg.start_point);
                first_ok = (first_p < P_W'(NUM_POINTS));
            end
            SWEEP_DOUBLE: begin
                if (r_cfg.start_point == '0) begin
                    first_p = P_W'(0);
                end else if (r_cfg.start_point <= POINT_W'(2)) begin
                    first_p = P_W'(1);
                end else if (r_cfg.start_point <= POINT_W'(4)) begin
                    first_p = P_W'(3);
                end else begin
                    first_p = P_W'(7);
                end
                first_ok = point_ok(first_p, r_cfg);
            end
            default: begin
                first_p  = P_W'(r_cfg.start_point);
                first_ok = point_ok(first_p, r_cfg);
            end
        endcase

        case (r_cfg.sweep_mode)
            SWEEP_DOUBLE:  next_p = P_W'({r_point, 1'b1});
            SWEEP_STRIDE2: next_p = P_W'(r_point) + P_W'(2);
            SWEEP_STRIDE1: next_p = P_W'(r_point) + P_W'(1);
            default:       next_p = P_W'(r_point);
        endcase
        next_ok = (r_cfg.sweep_mode != SWEEP_ONE) && point_ok(next_p, r_cfg);

        n_busy  = r_busy;
        n_point = r_point;
        n_drive = r_drive;
        n_count = r_count;
        n_sum   = r_sum;

        ctl               = '0;
        ctl.status        = ST_OK;
        ctl.point         = r_point;
        ctl.read_index    = i_read_index;

        case (i_opcode)
            OP_START: begin
                if (r_busy) begin
                    ctl.status = ST_IGNORED;
                end else begin
                    ctl.clear         = 1'b1;
                    ctl.drive_changed = 1'b1;
                    n_count           = '0;
                    n_sum             = '0;
                    if (first_ok) begin
                        n_busy  = 1'b1;
                        n_point = first_p[POINT_W-1:0];
                        n_drive = DRIVE_W'(first_p + P_W'(1));
                    end else begin
                        n_busy         = 1'b0;
                        n_drive        = '0;
                        ctl.sweep_done = 1'b1;
                    end
                end
            end
            OP_SAMPLE: begin
                if (!r_busy) begin
                    ctl.status = ST_IGNORED;
                end else begin
                    n_sum   = sum_inc;
                    n_count = count_inc;
                    if (count_inc == COUNT_W'(SAMPLES_PER_POINT)) begin
                        ctl.store         = (r_point < POINT_W'(NUM_POINTS));
                        ctl.drive_changed = 1'b1;
                        n_count           = '0;
                        n_sum             = '0;
                        if (next_ok) begin
                            n_point = next_p[POINT_W-1:0];
                            n_drive = DRIVE_W'(next_p + P_W'(1));
                        end else begin
                            n_busy         = 1'b0;
                            n_drive        = '0;
                            ctl.sweep_done = 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                if ((P_W'(i_read_index) >= P_W'(15)) ||
                    (P_W'(i_read_index) >= P_W'(NUM_POINTS))) begin
                    ctl.status = ST_MISMATCH;
                end else begin
                    ctl.read = 1'b1;
                end
            end
            default: begin
                ctl.status = ST_IGNORED;
            end
        endcase

        ctl.drive_code = n_drive;
        o_item.ctl     = ctl;
        o_item.sum     = sum_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_point <= '0;
            r_drive <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_fire) begin
            r_busy  <= n_busy;
            r_point <= n_point;
            r_drive <= n_drive;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_drive == '0) && (r_count == '0) && (r_sum == '0))
        else $error("idle sequencer holds drive or accumulator");

    a_busy_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_point < POINT_W'(NUM_POINTS)) &&
                   (r_drive == DRIVE_W'(r_point + POINT_W'(1))))
        else $error("drive code does not follow the active point");

endmodule

// File: rtl/dss_table.sv
// ---------------------------------------------------------------------------
// dss_table
// Result table: one entry per sweep point, valid bits cleared at reset and
// on sweep start, combinational read of one entry.
// ---------------------------------------------------------------------------
module dss_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  dss_pkg::t_tbl_req              i_req,
    output logic [dss_pkg::READING_W-1:0]  o_rd_data
);
    import dss_pkg::*;

    logic [READING_W-1:0]  r_data [NUM_POINTS];
    logic [NUM_POINTS-1:0] r_valid;
    logic                  rd_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr) begin
                r_valid[i_req.wr_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_req.wr) begin
            r_data[i_req.wr_index] <= i_req.wr_data;
        end
    end

    always_comb begin
        rd_in_range = (i_req.rd_index < POINT_W'(NUM_POINTS));
        o_rd_data   = '0;
        if (rd_in_range && r_valid[i_req.rd_index]) begin
            o_rd_data = r_data[i_req.rd_index];
        end
    end

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_req.clear |=> (r_valid == '0))
        else $error("table entries survive a sweep start");

endmodule

// File: rtl/diode_sweep_sequencer_core.sv
// ---------------------------------------------------------------------------
// diode_sweep_sequencer_core
// Test-current sweep sequencer with ADC averaging and a result table.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (i_valid/o_ready) carries opcode, ADC sample and read
//   index; one result per request leaves on o_valid/i_ready with drive code,
//   drive change flag, reading, status and sweep done flag.
//   Configuration channel (i_cfg_valid/o_cfg_ready) writes sweep mode, start
//   point and end point by index; it is always ready. Write only when no
//   request is in flight.
//   Pipeline: the sequencing decision is made in the accept cycle; the
//   request then passes registers p1, p2, p3 and out, with average multiply,
//   offset and scale multiply, then the reciprocal divide together with the
//   table access between them.
//   Throughput: one request per cycle while o_ready is high; the sequencing
//   state loop closes in the accept cycle.
//   Reset: idle, drive code 0, all table entries read as 0.
//   Receiver stall: the four-stage pipeline keeps accepting requests into
//   empty stages; o_ready drops only when all stages hold results.
// ---------------------------------------------------------------------------
module diode_sweep_sequencer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dss_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dss_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [dss_pkg::SAMPLE_W-1:0]   i_adc_sample,
    input  logic [dss_pkg::POINT_W-1:0]    i_read_index,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dss_pkg::DRIVE_W-1:0]    o_drive_code,
    output logic                           o_drive_changed,
    output logic [dss_pkg::READING_W-1:0]  o_reading,
    output logic [dss_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_sweep_done
);
    import dss_pkg::*;

    t_item                 item;
    logic                  fire;
    logic                  rdy_p1, rdy_p2, rdy_p3, rdy_out;

    logic                  r_p1_valid, r_p2_valid, r_p3_valid, r_out_valid;
    t_ctl                  r_p1_ctl, r_p2_ctl, r_p3_ctl;
    logic [SUM_W-1:0]      r_p1_sum;
    logic [AVG_W-1:0]      r_p2_avg;
    logic [SCALED_W-1:0]   r_p3_scaled;

    logic [SUM_W+AVG_MUL_W-1:0]  avg_prod;
    logic [SCALED_W+RECIP_W-1:0] div_prod;
    logic [READING_W-1:0]        value;
    logic [READING_W-1:0]        tbl_data;
    t_tbl_req                    tbl_req;
    logic                        tbl_en;

    logic [DRIVE_W-1:0]    r_out_drive;
    logic                  r_out_changed;
    logic [READING_W-1:0]  r_out_reading;
    t_status               r_out_status;
    logic                  r_out_done;

    assign o_cfg_ready = 1'b1;

    assign rdy_out = !r_out_valid || i_ready;
    assign rdy_p3  = !r_p3_valid  || rdy_out;
    assign rdy_p2  = !r_p2_valid  || rdy_p3;
    assign rdy_p1  = !r_p1_valid  || rdy_p2;
    assign o_ready = rdy_p1;
    assign fire    = i_valid && rdy_p1;

    dss_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (fire),
        .i_opcode     (i_opcode),
        .i_adc_sample (i_adc_sample),
        .i_read_index (i_read_index),
        .o_item       (item)
    );

    always_comb begin
        avg_prod = (SUM_W+AVG_MUL_W)'(r_p1_sum) * (SUM_W+AVG_MUL_W)'(AVG_MUL);
        div_prod = (SCALED_W+RECIP_W)'(r_p3_scaled) * (SCALED_W+RECIP_W)'(RECIP);
        value    = READING_W'(div_prod >> DIV_SHIFT);

        tbl_en           = rdy_out && r_p3_valid;
        tbl_req.clear    = r_p3_ctl.clear;
        tbl_req.wr       = r_p3_ctl.store;
        tbl_req.wr_index = r_p3_ctl.point;
        tbl_req.wr_data  = value;
        tbl_req.rd_index = r_p3_ctl.read_index;
    end

    dss_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (tbl_en),
        .i_req     (tbl_req),
        .o_rd_data (tbl_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy_p1) begin
                r_p1_valid <= fire;
            end
            if (rdy_p2) begin
                r_p2_valid <= r_p1_valid;
            end
            if (rdy_p3) begin
                r_p3_valid <= r_p2_valid;
            end
            if (rdy_out) begin
                r_out_valid <= r_p3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_p1) begin
            r_p1_ctl <= item.ctl;
            r_p1_sum <= item.sum;
        end
        if (rdy_p2) begin
            r_p2_ctl <= r_p1_ctl;
            r_p2_avg <= AVG_W'(avg_prod >> AVG_SHIFT);
        end
        if (rdy_p3) begin
            r_p3_ctl    <= r_p2_ctl;
            r_p3_scaled <= (SCALED_W'(r_p2_avg) + SCALED_W'(AVG_BIAS))
                           * SCALED_W'(SCALE_MUL);
        end
        if (rdy_out) begin
            r_out_drive   <= r_p3_ctl.drive_code;
            r_out_changed <= r_p3_ctl.drive_changed;
            r_out_status  <= r_p3_ctl.status;
            r_out_done    <= r_p3_ctl.sweep_done;
            if (r_p3_ctl.store) begin
                r_out_reading <= value;
            end else if (r_p3_ctl.read) begin
                r_out_reading <= tbl_data;
            end else begin
                r_out_reading <= '0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive_code    = r_out_drive;
    assign o_drive_changed = r_out_changed;
    assign o_reading       = r_out_reading;
    assign o_status        = r_out_status;
    assign o_sweep_done    = r_out_done;

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_p1_valid && r_p2_valid && r_p3_valid && r_out_valid)
        else $error("request stalled while a pipeline stage is empty");

    a_done_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sweep_done |-> (o_drive_code == '0) && o_drive_changed)
        else $error("sweep done without drive switched off");

    a_mismatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_MISMATCH) |-> (o_reading == '0))
        else $error("index mismatch carries a reading");

endmodule

// File: tb/tb_diode_sweep_sequencer_core.sv
// ---------------------------------------------------------------------------
// tb_diode_sweep_sequencer_core
// Self-checking bench for the diode sweep sequencer core. A clocked driver
// feeds requests from a queue; a monitor predicts each accepted request's
// readout (drive code, change flag, reading, status, done) and compares
// every returned result in order. A directed block covers the edge cases,
// then random sweeps with random content and noise run under three
// back-pressure profiles while the sweep registers are reprogrammed between
// sweeps.
// ---------------------------------------------------------------------------
module tb_diode_sweep_sequencer_core;
    import dss_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED     = 2'd3;
    localparam logic [POINT_W-1:0]  BAD_INDEX     = 4'd15;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = '1;
    localparam int                  RANDOM_ITEMS  = 900;
    localparam int                  DRAIN_CYCLES  = 8;
    localparam int                  STALL_LIMIT   = 2000;
    localparam int                  MAX_REPORTS   = 10;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [SAMPLE_W-1:0] sample;
        logic [POINT_W-1:0]  ridx;
    } t_req;

    typedef struct packed {
        logic [DRIVE_W-1:0]   drive;
        logic                 changed;
        logic [READING_W-1:0] reading;
        t_status              status;
        logic                 done;
    } t_readout;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   i_valid       = 1'b0;
    logic                   o_ready;
    logic [OPCODE_W-1:0]    i_opcode      = '0;
    logic [SAMPLE_W-1:0]    i_adc_sample  = '0;
    logic [POINT_W-1:0]     i_read_index  = '0;
    logic                   o_valid;
    logic                   i_ready       = 1'b0;
    logic [DRIVE_W-1:0]     o_drive_code;
    logic                   o_drive_changed;
    logic [READING_W-1:0]   o_reading;
    logic [STATUS_W-1:0]    o_status;
    logic                   o_sweep_done;

    diode_sweep_sequencer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_adc_sample    (i_adc_sample),
        .i_read_index    (i_read_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_drive_code    (o_drive_code),
        .o_drive_changed (o_drive_changed),
        .o_reading       (o_reading),
        .o_status        (o_status),
        .o_sweep_done    (o_sweep_done)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_req     request_q[$];
    t_readout readout_q[$];
    t_req     drive_item;
    t_req     seen_req;
    t_readout got_readout;
    t_readout exp_readout;
    logic     req_fire      = 1'b0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       items_pushed  = 0;
    int       readouts_seen = 0;
    int       err_count     = 0;
    int       stall_cycles  = 0;

    t_mode                cfg_mode  = SWEEP_ONE;
    logic [POINT_W-1:0]   cfg_start = '0;
    logic [POINT_W-1:0]   cfg_end   = '0;
    logic                 sw_busy   = 1'b0;
    logic [POINT_W-1:0]   cur_point = '0;
    logic [DRIVE_W-1:0]   sw_drive  = '0;
    logic [COUNT_W-1:0]   acc_cnt   = '0;
    logic [SUM_W-1:0]     acc_sum   = '0;
    logic [READING_W-1:0] stored_reading[NUM_POINTS];

    initial foreach (stored_reading[i]) stored_reading[i] = '0;

    function automatic bit point_fits(input t_mode m, input logic [POINT_W-1:0] ep,
                                      input int idx);
        if (idx >= NUM_POINTS) return 1'b0;
        if (m == SWEEP_DOUBLE) return (idx + 1) <= ep;
        return idx <= ep;
    endfunction

    function automatic bit first_point(input t_mode m, input logic [POINT_W-1:0] sp,
                                       input logic [POINT_W-1:0] ep, output int idx);
        int p;
        p = int'(sp);
        if (m == SWEEP_ONE) begin
            idx = p;
            return p < NUM_POINTS;
        end
        if (m == SWEEP_DOUBLE) begin
            if (sp == 0) p = 0;
            else if (sp <= 2) p = 1;
            else if (sp <= 4) p = 3;
            else p = 7;
        end
        idx = p;
        return point_fits(m, ep, p);
    endfunction

    function automatic bit next_point(input t_mode m, input logic [POINT_W-1:0] ep,
                                      input int cur, output int idx);
        int p;
        case (m)
            SWEEP_ONE:     return 1'b0;
            SWEEP_DOUBLE:  p = ((cur + 1) << 1) - 1;
            SWEEP_STRIDE2: p = cur + 2;
            default:       p = cur + 1;
        endcase
        idx = p;
        return point_fits(m, ep, p);
    endfunction

    function automatic int count_points(input t_mode m, input logic [POINT_W-1:0] sp,
                                        input logic [POINT_W-1:0] ep);
        int idx;
        int nxt;
        int n;
        n = 0;
        if (first_point(m, sp, ep, idx)) begin
            n = 1;
            while (next_point(m, ep, idx, nxt)) begin
                idx = nxt;
                n++;
            end
        end
        return n;
    endfunction

    function automatic void enter_point(input int idx);
        cur_point = idx[POINT_W-1:0];
        sw_drive  = DRIVE_W'(idx + 1);
        acc_cnt   = '0;
        acc_sum   = '0;
        sw_busy   = 1'b1;
    endfunction

    function automatic void close_sweep();
        sw_busy  = 1'b0;
        sw_drive = '0;
        acc_cnt  = '0;
        acc_sum  = '0;
    endfunction

    function automatic t_readout predict_readout(input t_req r);
        t_readout o;
        int       idx;
        int       avg;
        int       val;
        o = '{drive: '0, changed: 1'b0, reading: '0, status: ST_OK, done: 1'b0};
        case (r.op)
            OP_START: begin
                if (sw_busy) begin
                    o.status = ST_IGNORED;
                end else begin
                    foreach (stored_reading[i]) stored_reading[i] = '0;
                    o.changed = 1'b1;
                    if (first_point(cfg_mode, cfg_start, cfg_end, idx)) begin
                        enter_point(idx);
                    end else begin
                        close_sweep();
                        o.done = 1'b1;
                    end
                end
            end
            OP_SAMPLE: begin
                if (!sw_busy) begin
                    o.status = ST_IGNORED;
                end else begin
                    acc_sum = acc_sum + r.sample;
                    acc_cnt = acc_cnt + 1'b1;
                    if (acc_cnt == SAMPLES_PER_POINT) begin
                        avg = acc_sum / SAMPLES_PER_POINT;
                        val = ((avg + AVG_BIAS) * SCALE_MUL) / SCALE_DIV;
                        stored_reading[cur_point] = val[READING_W-1:0];
                        o.reading = val[READING_W-1:0];
                        o.changed = 1'b1;
                        if (next_point(cfg_mode, cfg_end, cur_point, idx)) begin
                            enter_point(idx);
                        end else begin
                            close_sweep();
                            o.done = 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                if (r.ridx >= NUM_POINTS) o.status = ST_MISMATCH;
                else o.reading = stored_reading[r.ridx];
            end
            default: o.status = ST_IGNORED;
        endcase
        o.drive = sw_drive;
        return o;
    endfunction

    function automatic string fmt_readout(input t_readout r);
        return $sformatf("drive=%0d chg=%0d rd=%0d st=%0d done=%0d",
                         r.drive, r.changed, r.reading, r.status, r.done);
    endfunction

    task automatic note_failure(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // hold valid and payload until the request is taken
    always @(negedge i_clk) begin
        if (!i_valid || req_fire) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_item = request_q.pop_front();
                i_valid      <= 1'b1;
                i_opcode     <= drive_item.op;
                i_adc_sample <= drive_item.sample;
                i_read_index <= drive_item.ridx;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_fire <= 1'b0;
            stall_cycles = 0;
        end else begin
            req_fire <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                seen_req = {i_opcode, i_adc_sample, i_read_index};
                readout_q.push_back(predict_readout(seen_req));
            end
            if (o_valid && i_ready) begin
                readouts_seen++;
                got_readout = '{drive: o_drive_code, changed: o_drive_changed,
                                reading: o_reading, status: t_status'(o_status),
                                done: o_sweep_done};
                if (readout_q.size() == 0) begin
                    note_failure({"unexpected result: ", fmt_readout(got_readout)});
                end else begin
                    exp_readout = readout_q.pop_front();
                    if (got_readout !== exp_readout)
                        note_failure({"mismatch: exp ", fmt_readout(exp_readout),
                                      ", got ", fmt_readout(got_readout)});
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [OPCODE_W-1:0] op, input logic [SAMPLE_W-1:0] sample,
                            input logic [POINT_W-1:0] ridx);
        request_q.push_back('{op: op, sample: sample, ridx: ridx});
        items_pushed++;
    endtask

    task automatic drain();
        while (readouts_seen != items_pushed) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SWEEP_MODE:  cfg_mode  = t_mode'(data[MODE_W-1:0]);
            CFG_START_POINT: cfg_start = data;
            CFG_END_POINT:   cfg_end   = data;
            default: ;
        endcase
    endtask

    task automatic configure(input t_mode m, input logic [POINT_W-1:0] sp,
                             input logic [POINT_W-1:0] ep);
        drain();
        write_reg(CFG_SWEEP_MODE, CFG_DATA_W'(m));
        write_reg(CFG_START_POINT, sp);
        write_reg(CFG_END_POINT, ep);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_noise(input bit sweeping);
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            push_req(OP_READ, SAMPLE_W'($urandom_range(4095)), POINT_W'($urandom_range(15)));
        else if (pick < 8)
            push_req(OP_UNUSED, SAMPLE_W'($urandom_range(4095)), POINT_W'($urandom_range(15)));
        else if (sweeping)
            push_req(OP_START, SAMPLE_W'($urandom_range(4095)), POINT_W'($urandom_range(15)));
        else
            push_req(OP_SAMPLE, SAMPLE_W'($urandom_range(4095)), POINT_W'($urandom_range(15)));
    endtask

    task automatic run_sweep(input t_mode m, input logic [POINT_W-1:0] sp,
                             input logic [POINT_W-1:0] ep);
        int npts;
        int style;
        int base;
        logic [SAMPLE_W-1:0] smp;
        configure(m, sp, ep);
        npts = count_points(m, sp, ep);
        repeat ($urandom_range(2)) push_noise(1'b0);
        push_req(OP_START, SAMPLE_W'($urandom_range(4095)), POINT_W'($urandom_range(15)));
        repeat (npts) begin
            style = $urandom_range(4);
            base  = $urandom_range(4095);
            repeat (SAMPLES_PER_POINT) begin
                if ($urandom_range(9) == 0) push_noise(1'b1);
                case (style)
                    1:       smp = SAMPLE_MAX;
                    2:       smp = '0;
                    3:       smp = SAMPLE_W'(base) ^ SAMPLE_W'($urandom_range(63));
                    default: smp = SAMPLE_W'($urandom_range(4095));
                endcase
                push_req(OP_SAMPLE, smp, POINT_W'($urandom_range(15)));
            end
        end
        repeat ($urandom_range(1, 5)) push_noise(1'b0);
    endtask

    t_mode              edge_mode[6]  = '{SWEEP_STRIDE1, SWEEP_DOUBLE, SWEEP_STRIDE2,
                                          SWEEP_ONE, SWEEP_DOUBLE, SWEEP_STRIDE1};
    logic [POINT_W-1:0] edge_start[6] = '{4'd0, 4'd0, 4'd0, 4'd14, 4'd5, 4'd14};
    logic [POINT_W-1:0] edge_end[6]   = '{4'd14, 4'd14, 4'd14, 4'd0, 4'd7, 4'd0};

    initial begin
        int target;
        int sweep_no;
        t_mode              m;
        logic [POINT_W-1:0] sp;
        logic [POINT_W-1:0] ep;

        send_idle_pct = 6;
        recv_idle_pct = 53;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle block: stray sample, bad read, unknown opcode, empty table
        push_req(OP_SAMPLE, SAMPLE_MAX, 4'd0);
        push_req(OP_READ, '0, BAD_INDEX);
        push_req(OP_UNUSED, SAMPLE_MAX, BAD_INDEX);
        push_req(OP_READ, SAMPLE_MAX, 4'd0);

        // single point at the top of the table, full-scale samples
        configure(SWEEP_ONE, 4'd14, 4'd0);
        push_req(OP_START, '0, 4'd0);
        push_req(OP_START, SAMPLE_MAX, BAD_INDEX);
        push_req(OP_READ, '0, BAD_INDEX);
        repeat (SAMPLES_PER_POINT) push_req(OP_SAMPLE, SAMPLE_MAX, 4'd0);
        push_req(OP_READ, '0, 4'd14);
        push_req(OP_READ, '0, 4'd0);

        // empty sweeps: start beyond end, doubling first drive above end
        configure(SWEEP_STRIDE2, 4'd5, 4'd3);
        push_req(OP_START, '0, 4'd0);
        push_req(OP_READ, '0, 4'd14);
        configure(SWEEP_DOUBLE, 4'd8, 4'd7);
        push_req(OP_START, '0, 4'd0);

        target   = items_pushed + RANDOM_ITEMS;
        sweep_no = 0;
        while (items_pushed < target) begin
            drain();
            if (items_pushed < target - 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 53;
            end else if (items_pushed < target - RANDOM_ITEMS / 3) begin
                send_idle_pct = 53;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (sweep_no < 6) begin
                m  = edge_mode[sweep_no];
                sp = edge_start[sweep_no];
                ep = edge_end[sweep_no];
            end else begin
                m  = t_mode'(MODE_W'($urandom_range(3)));
                sp = POINT_W'($urandom_range(14));
                if ($urandom_range(4) == 0)
                    ep = POINT_W'($urandom_range(14));
                else
                    ep = POINT_W'($urandom_range(14, sp));
            end
            run_sweep(m, sp, ep);
            sweep_no++;
        end

        drain();
        if (readout_q.size() != 0)
            note_failure($sformatf("%0d results never returned", readout_q.size()));
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
